// ===== hw/rtl/kdch_pkg.sv =====
// kdch_pkg: shared types and codes for the key debounce / click / hold / repeat bank.
// No dependencies; used by kdch_lane, kdch_merge and key_debounce_click_hold_repeat.
`default_nettype none

package kdch_pkg;

  // Item kinds carried on in_tuser
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_CHECK = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // Per key mode
  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_CLICK = 2'd1,
    MODE_HOLD  = 2'd2
  } mode_t;

  // Status codes returned by a read
  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_CLICK_EV = 3'd1;
  localparam logic [2:0] ST_CLICK    = 3'd2;
  localparam logic [2:0] ST_HOLD_EV  = 3'd3;
  localparam logic [2:0] ST_HOLD     = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [1:0] CFG_HOLD     = 2'd1;
  localparam logic [1:0] CFG_REPEAT   = 2'd2;
  localparam logic [1:0] CFG_INV_MASK = 2'd3;

  localparam int PIN_BITS = 8;

  typedef struct packed {
    logic [7:0]  debounce_ticks;
    logic [15:0] hold_ticks;
    logic [15:0] repeat_ticks;
  } cfg_t;

  // Control towards one lane for the item being accepted
  typedef struct packed {
    logic       tick;   // tick item accepted
    logic       sel;    // read/check accepted and addressed to this lane
    logic       rd;     // the query is a read (else a check)
    logic [2:0] asked;  // asked state of a check
  } lane_ctl_t;

  // What a lane reports to the merge stage
  typedef struct packed {
    mode_t mode;     // mode before the item
    logic  pending;  // event pending before the item
    logic  deb_nxt;  // debounced level after the item
  } lane_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/kdch_lane.sv =====
// kdch_lane: one key qualifier - debounce, then idle/click/hold mode tracking.
// Depends on kdch_pkg.
`default_nettype none

module kdch_lane (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire kdch_pkg::cfg_t      cfg,
  input  wire kdch_pkg::lane_ctl_t ctl,
  input  wire logic                pin_level,
  input  wire logic                inv_level,
  output kdch_pkg::lane_stat_t     stat
);

  logic             last_r, last_nxt;
  logic [7:0]       run_r, run_nxt;
  logic             deb_r, deb_nxt;
  kdch_pkg::mode_t  mode_r, mode_nxt;
  logic [15:0]      cnt_r, cnt_nxt;
  logic             pend_r, pend_nxt;

  logic             now;
  logic [15:0]      cnt_inc;
  logic             clr;

  assign now     = pin_level ^ inv_level;
  assign cnt_inc = (cnt_r == 16'hFFFF) ? cnt_r : cnt_r + 16'd1;

  // a read, or a check whose asked state matches the mode, clears the pending event of a click or hold key
  always_comb begin
    clr = 1'b0;
    if (ctl.sel && mode_r != kdch_pkg::MODE_IDLE) begin
      if (ctl.rd) begin
        clr = 1'b1;
      end else begin
        clr = (ctl.asked == {1'b0, mode_r});
      end
    end
  end

  always_comb begin
    last_nxt = last_r;
    run_nxt  = run_r;
    deb_nxt  = deb_r;
    mode_nxt = mode_r;
    cnt_nxt  = cnt_r;
    pend_nxt = pend_r & ~clr;
    if (ctl.tick) begin
      if (now == last_r) begin
        run_nxt = (run_r == 8'hFF) ? run_r : run_r + 8'd1;
      end else begin
        run_nxt = 8'd0;
      end
      last_nxt = now;
      if (run_nxt == cfg.debounce_ticks) begin
        deb_nxt = now;
      end
      unique case (mode_r)
        kdch_pkg::MODE_IDLE: begin
          if (deb_nxt) begin
            mode_nxt = kdch_pkg::MODE_CLICK;
            cnt_nxt  = 16'd0;
            pend_nxt = 1'b1;
          end
        end
        kdch_pkg::MODE_CLICK: begin
          if (deb_nxt) begin
            if (cnt_inc > cfg.hold_ticks) begin
              mode_nxt = kdch_pkg::MODE_HOLD;
              cnt_nxt  = 16'd0;
              pend_nxt = 1'b1;
            end else begin
              cnt_nxt = cnt_inc;
            end
          end else begin
            mode_nxt = kdch_pkg::MODE_IDLE;
          end
        end
        kdch_pkg::MODE_HOLD: begin
          if (deb_nxt) begin
            if (cnt_inc > cfg.repeat_ticks) begin
              cnt_nxt  = 16'd0;
              pend_nxt = 1'b1;
            end else begin
              cnt_nxt = cnt_inc;
            end
          end else begin
            mode_nxt = kdch_pkg::MODE_IDLE;
          end
        end
        default: mode_nxt = kdch_pkg::MODE_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= 1'b0;
      run_r  <= 8'd0;
      deb_r  <= 1'b0;
      mode_r <= kdch_pkg::MODE_IDLE;
      cnt_r  <= 16'd0;
      pend_r <= 1'b0;
    end else begin
      last_r <= last_nxt;
      run_r  <= run_nxt;
      deb_r  <= deb_nxt;
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
      pend_r <= pend_nxt;
    end
  end

  assign stat.mode    = mode_r;
  assign stat.pending = pend_r;
  assign stat.deb_nxt = deb_nxt;

endmodule

`default_nettype wire

// ===== hw/rtl/kdch_merge.sv =====
// kdch_merge: combines lane reports into one result item and holds the output register.
// Depends on kdch_pkg; fed by the kdch_lane instances.
`default_nettype none

module kdch_merge #(
  parameter int NUM_KEYS = 8,
  parameter int IDXW     = 3
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 acc,
  input  wire kdch_pkg::op_t        op,
  input  wire logic                 err,
  input  wire logic [IDXW-1:0]      idx,
  input  wire logic [2:0]           asked,
  input  wire kdch_pkg::lane_stat_t lane_st [NUM_KEYS],
  output logic                      ready,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [15:0]               out_tdata
);

  kdch_pkg::lane_stat_t sel_st;
  logic [2:0]           status;
  logic                 matched;
  logic [7:0]           pressed;
  logic                 valid_r, valid_nxt;
  logic [15:0]          data_r;

  assign sel_st = lane_st[idx];

  always_comb begin
    status  = kdch_pkg::ST_IDLE;
    matched = 1'b0;
    if (!err && op == kdch_pkg::OP_READ) begin
      unique case (sel_st.mode)
        kdch_pkg::MODE_CLICK:
          status = sel_st.pending ? kdch_pkg::ST_CLICK_EV : kdch_pkg::ST_CLICK;
        kdch_pkg::MODE_HOLD:
          status = sel_st.pending ? kdch_pkg::ST_HOLD_EV : kdch_pkg::ST_HOLD;
        default: status = kdch_pkg::ST_IDLE;
      endcase
    end
    if (!err && op == kdch_pkg::OP_CHECK) begin
      matched = (asked == {1'b0, sel_st.mode}) &&
                (sel_st.mode == kdch_pkg::MODE_IDLE || sel_st.pending);
    end
  end

  // only keys 0..7 appear in the mask
  for (genvar k = 0; k < kdch_pkg::PIN_BITS; k++) begin : g_mask
    if (k < NUM_KEYS) begin : g_on
      assign pressed[k] = lane_st[k].deb_nxt;
    end else begin : g_off
      assign pressed[k] = 1'b0;
    end
  end

  assign ready     = !valid_r || out_tready;
  assign valid_nxt = acc || (valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      data_r <= {3'b000, err, pressed, matched, status};
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;

endmodule

`default_nettype wire

// ===== hw/rtl/key_debounce_click_hold_repeat.sv =====
// key_debounce_click_hold_repeat: top level of a bank of debounced keys with
// click, hold and autorepeat events. Depends on kdch_pkg, kdch_lane, kdch_merge.
//
// Use:
//  - in_* is the item channel. in_tuser carries the kind: tick (pin levels in
//    in_tdata), read a key's status, or check a key against an asked state.
//    Reads and checks with a matching event clear the key's pending event.
//  - out_* returns exactly one result item per accepted item, in order.
//  - cfg_* writes the four registers (debounce, hold, repeat, active-low mask);
//    write only while no item is in flight. No read-back.
// Pipeline and rate:
//  - one lane per key updates in parallel from its own registers, so an item
//    is accepted every cycle while the output is not stalled; the result
//    appears in the merge stage's output register in the cycle after acceptance.
//  - in_tready = output register empty or being taken this cycle. When the
//    receiver stalls, the held result stays put and input stalls behind it.
// Reset (rst_n low, synchronous): all keys idle, not pressed, no events,
//  counters zero; registers to 20 / 1000 / 200 / 0xFF; output empty.
//  No clearing pass is needed; the block is ready the cycle after reset.
`default_nettype none

module key_debounce_click_hold_repeat #(
  parameter int NUM_KEYS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // in_tdata, from bit 0: pin_levels[7:0], key_index[15:8], asked_state[18:16], zeros
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,
  // in_tuser: op[1:0]
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // out_tdata, from bit 0: status[2:0], matched[3], pressed_mask[11:4],
  // index_error[12], zeros
  output logic [15:0]      out_tdata,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  localparam int IDXW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  // configuration registers
  logic [7:0]  debounce_r;
  logic [15:0] hold_r;
  logic [15:0] repeat_r;
  logic [7:0]  inv_mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= 8'd20;
      hold_r     <= 16'd1000;
      repeat_r   <= 16'd200;
      inv_mask_r <= 8'hFF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kdch_pkg::CFG_DEBOUNCE: debounce_r <= cfg_wdata[7:0];
        kdch_pkg::CFG_HOLD:     hold_r     <= cfg_wdata;
        kdch_pkg::CFG_REPEAT:   repeat_r   <= cfg_wdata;
        kdch_pkg::CFG_INV_MASK: inv_mask_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  kdch_pkg::cfg_t cfg;
  assign cfg.debounce_ticks = debounce_r;
  assign cfg.hold_ticks     = hold_r;
  assign cfg.repeat_ticks   = repeat_r;

  // item decode
  logic            acc;
  kdch_pkg::op_t   op;
  logic [7:0]      pins;
  logic [7:0]      key_index;
  logic [2:0]      asked;
  logic            query;
  logic            err;
  logic [IDXW-1:0] idx;

  assign acc       = in_tvalid && in_tready;
  assign op        = kdch_pkg::op_t'(in_tuser);
  assign pins      = in_tdata[7:0];
  assign key_index = in_tdata[15:8];
  assign asked     = in_tdata[18:16];
  assign query     = (op == kdch_pkg::OP_READ) || (op == kdch_pkg::OP_CHECK);
  assign err       = query && (key_index >= 8'(NUM_KEYS));
  assign idx       = key_index[IDXW-1:0];

  kdch_pkg::lane_stat_t lane_st [NUM_KEYS];

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    kdch_pkg::lane_ctl_t ctl;
    logic                pin;
    logic                al;

    // keys above the pin word see level 0, active high
    if (k < kdch_pkg::PIN_BITS) begin : g_pin
      assign pin = pins[k];
      assign al  = inv_mask_r[k];
    end else begin : g_nopin
      assign pin = 1'b0;
      assign al  = 1'b0;
    end

    assign ctl.tick  = acc && (op == kdch_pkg::OP_TICK);
    assign ctl.sel   = acc && query && !err && (idx == IDXW'(k));
    assign ctl.rd    = (op == kdch_pkg::OP_READ);
    assign ctl.asked = asked;

    kdch_lane u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .cfg       (cfg),
      .ctl       (ctl),
      .pin_level (pin),
      .inv_level (al),
      .stat      (lane_st[k])
    );
  end

  kdch_merge #(
    .NUM_KEYS (NUM_KEYS),
    .IDXW     (IDXW)
  ) u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .op         (op),
    .err        (err),
    .idx        (idx),
    .asked      (asked),
    .lane_st    (lane_st),
    .ready      (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

`ifndef SYNTHESIS
  // every accepted item produces a result the next cycle
  a_acc_result: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> out_tvalid)
    else $error("accepted item gave no result");

  // a tick never reports a status, a match or an index error
  a_tick_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && op == kdch_pkg::OP_TICK) |=>
      (out_tdata[2:0] == kdch_pkg::ST_IDLE && !out_tdata[3] && !out_tdata[12]))
    else $error("tick result carries query fields");

  // unused kind leaves status, match and error clear
  a_none_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && op == kdch_pkg::OP_NONE) |=>
      (out_tdata[2:0] == kdch_pkg::ST_IDLE && !out_tdata[3] && !out_tdata[12]))
    else $error("unused kind gave a non-zero result");

  // an index error goes with no status and no match
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[12]) |->
      (out_tdata[2:0] == kdch_pkg::ST_IDLE && !out_tdata[3]))
    else $error("index error with status or match");

  // status and match are never both set
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[3] && out_tdata[2:0] != kdch_pkg::ST_IDLE))
    else $error("status and match set together");
`endif

endmodule

`default_nettype wire
